[rtl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the encoder speed PI controller
// Register indexes, reset values, sequencer states and multiplier handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  localparam int ACC_W  = 48;   // serial multiplier accumulator width
  localparam int MPL_W  = 16;   // multiplier operand width (one bit per cycle)
  localparam int CNT_W  = 5;    // bit counter, holds MPL_W
  localparam int CIDX_W = 4;    // config register index width
  localparam int CDAT_W = 16;   // config write data width

  localparam logic [CIDX_W-1:0] CFG_COUNT_OFFSET  = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_RPM_PER_COUNT = 4'd1;
  localparam logic [CIDX_W-1:0] CFG_RPM_LIMIT     = 4'd2;
  localparam logic [CIDX_W-1:0] CFG_FILTER_ALPHA  = 4'd3;
  localparam logic [CIDX_W-1:0] CFG_SPEED_GAIN    = 4'd4;
  localparam logic [CIDX_W-1:0] CFG_PROP_GAIN     = 4'd5;
  localparam logic [CIDX_W-1:0] CFG_INTEG_GAIN    = 4'd6;
  localparam logic [CIDX_W-1:0] CFG_INTEG_LIMIT   = 4'd7;

  localparam logic [15:0] RST_COUNT_OFFSET  = 16'd20000;
  localparam logic [9:0]  RST_RPM_PER_COUNT = 10'd30;
  localparam logic [14:0] RST_RPM_LIMIT     = 15'd5000;
  localparam logic [15:0] RST_FILTER_ALPHA  = 16'd6554;
  localparam logic [15:0] RST_SPEED_GAIN    = 16'd110;
  localparam logic [15:0] RST_PROP_GAIN     = 16'd256;
  localparam logic [15:0] RST_INTEG_GAIN    = 16'd0;
  localparam logic [14:0] RST_INTEG_LIMIT   = 15'd25600;

  localparam logic [CNT_W-1:0] NBITS_RPM  = 5'd10;
  localparam logic [CNT_W-1:0] NBITS_FULL = 5'd16;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RAW  = 7'b0000010,
    ST_FILT = 7'b0000100,
    ST_MEAS = 7'b0001000,
    ST_PROP = 7'b0010000,
    ST_INTG = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] mcand;
    logic [MPL_W-1:0] mplier;
    logic [CNT_W-1:0] nbits;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] acc;
  } mul_rsp_t;

endpackage

`default_nettype wire

[rtl/spc_if.sv]
// ----------------------------------------------------------------------------
// spc_if: channel interfaces of the encoder speed PI controller
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] encoder_count;
  logic signed [15:0] target_speed;
  modport source (output valid, output encoder_count, output target_speed, input ready);
  modport sink   (input valid, input encoder_count, input target_speed, output ready);
endinterface

interface spc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_speed;
  logic        [14:0] measured_speed;
  logic signed [16:0] speed_error;
  logic signed [15:0] filtered_rpm;
  logic               rpm_rejected;
  logic signed [31:0] impulse_total;
  modport source (output valid, output drive_speed, output measured_speed,
                  output speed_error, output filtered_rpm, output rpm_rejected,
                  output impulse_total, input ready);
  modport sink   (input valid, input drive_speed, input measured_speed,
                  input speed_error, input filtered_rpm, input rpm_rejected,
                  input impulse_total, output ready);
endinterface

interface spc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  idx;
  logic [15:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

[rtl/spc_mul.sv]
// ----------------------------------------------------------------------------
// spc_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle, LSB first; product kept modulo 2^ACC_W.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_mul (
  input  wire               clk,
  input  wire               rst_n,
  input  spc_pkg::mul_req_t req,
  output spc_pkg::mul_rsp_t rsp
);
  import spc_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] mcand_r;
  logic [MPL_W-1:0] mplier_r;

  assign acc_nxt = mplier_r[0] ? acc_r + mcand_r : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= '0;
      mcand_r  <= req.mcand;
      mplier_r <= req.mplier;
      cnt_r    <= req.nbits;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[ACC_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MPL_W-1:1]};
      cnt_r    <= cnt_r - CNT_W'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.acc  = acc_r;

endmodule

`default_nettype wire

[rtl/encoder_speed_pi_controller_unit.sv]
// ----------------------------------------------------------------------------
// encoder_speed_pi_controller_unit: encoder rpm filter and PI speed loop
// Sequencer around one bit-serial multiplier: rpm, filter, speed, P, I terms.
// ----------------------------------------------------------------------------
// Steps: the rpm product with its 10-bit multiplier, then the filter, speed,
// P and I terms as 16-bit products, then the load of the output register.
// All products run in turn on the shared serial multiplier, and a new sample
// is taken only once the sequencer is back in idle, so one is in work at a time.
// The result register lets the next sample start while a result waits.
// Reset (rst_n low, synchronous): registers to defaults, filter, integral
// and impulse total cleared, no result pending.
`default_nettype none

module encoder_speed_pi_controller_unit (
  input  wire       clk,
  input  wire       rst_n,
  spc_in_if.sink    in_ch,
  spc_out_if.source out_ch,
  spc_cfg_if.sink   cfg_ch
);
  import spc_pkg::*;

  // configuration
  logic [15:0] count_offset_r;
  logic [9:0]  rpm_per_count_r;
  logic [14:0] rpm_limit_r;
  logic [15:0] alpha_r;
  logic [15:0] speed_gain_r;
  logic [15:0] prop_gain_r;
  logic [15:0] integ_gain_r;
  logic [14:0] integ_limit_r;

  // state
  state_t             state_r, state_nxt;
  logic signed [31:0] yfilt_r;
  logic signed [15:0] integ_r;
  logic        [31:0] impulse_r;

  // per-item working registers
  logic signed [15:0] target_r;
  logic               rej_r;
  logic        [14:0] meas_r;
  logic signed [16:0] err_r;
  logic signed [25:0] pterm_r;
  logic signed [15:0] drive_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] o_drive_r;
  logic        [14:0] o_meas_r;
  logic signed [16:0] o_err_r;
  logic signed [15:0] o_rpm_r;
  logic               o_rej_r;
  logic        [31:0] o_imp_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  spc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  logic               in_acc;
  logic signed [16:0] diff;
  logic signed [26:0] raw;
  logic        [26:0] raw_mag;
  logic               rej;
  logic        [47:0] fdelta;
  logic signed [31:0] ynew;
  logic        [31:0] ymag;
  logic        [23:0] mfull;
  logic        [14:0] meas;
  logic signed [16:0] err;
  logic signed [17:0] isum, ilim, iclamp;
  logic signed [23:0] iterm;
  logic signed [26:0] dsum;
  logic               out_load;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    diff    = $signed({1'b0, in_ch.encoder_count}) - $signed({1'b0, count_offset_r});
    raw     = $signed(mrsp.acc[26:0]);
    raw_mag = raw[26] ? 27'(-raw) : 27'(raw);
    rej     = raw_mag >= {12'd0, rpm_limit_r};
    fdelta  = rej ? '0 : ({{5{raw[26]}}, raw, 16'd0} - {{16{yfilt_r[31]}}, yfilt_r});
    ynew    = yfilt_r + $signed(mrsp.acc[47:16]);
    ymag    = ynew[31] ? 32'(-ynew) : 32'(ynew);
    mfull   = mrsp.acc[47:24];
    meas    = (|mfull[23:15]) ? 15'h7fff : mfull[14:0];
    err     = {target_r[15], target_r} - $signed({2'b00, meas});
    isum    = {{2{integ_r[15]}}, integ_r} + {err[16], err};
    ilim    = $signed({3'b000, integ_limit_r});
    if (isum > ilim)       iclamp = ilim;
    else if (isum < -ilim) iclamp = -ilim;
    else                   iclamp = isum;
    iterm   = $signed(mrsp.acc[31:8]);
    dsum    = {{11{target_r[15]}}, target_r} + {pterm_r[25], pterm_r}
              + {{3{iterm[23]}}, iterm};
    out_load = !out_valid_r || out_ch.ready;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mreq.start  = 1'b0;
    mreq.mcand  = '0;
    mreq.mplier = '0;
    mreq.nbits  = NBITS_FULL;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mreq.start  = 1'b1;
          mreq.mcand  = {{31{diff[16]}}, diff};
          mreq.mplier = {6'd0, rpm_per_count_r};
          mreq.nbits  = NBITS_RPM;
          state_nxt   = ST_RAW;
        end
      end
      ST_RAW: begin
        if (mrsp.done) begin
          mreq.start  = 1'b1;
          mreq.mcand  = fdelta;
          mreq.mplier = alpha_r;
          state_nxt   = ST_FILT;
        end
      end
      ST_FILT: begin
        if (mrsp.done) begin
          mreq.start  = 1'b1;
          mreq.mcand  = {16'd0, ymag};
          mreq.mplier = speed_gain_r;
          state_nxt   = ST_MEAS;
        end
      end
      ST_MEAS: begin
        if (mrsp.done) begin
          mreq.start  = 1'b1;
          mreq.mcand  = {{31{err[16]}}, err};
          mreq.mplier = prop_gain_r;
          state_nxt   = ST_PROP;
        end
      end
      ST_PROP: begin
        if (mrsp.done) begin
          // integral already clamped and stored at the end of ST_MEAS
          mreq.start  = 1'b1;
          mreq.mcand  = {{32{integ_r[15]}}, integ_r};
          mreq.mplier = integ_gain_r;
          state_nxt   = ST_INTG;
        end
      end
      ST_INTG: begin
        if (mrsp.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      count_offset_r  <= RST_COUNT_OFFSET;
      rpm_per_count_r <= RST_RPM_PER_COUNT;
      rpm_limit_r     <= RST_RPM_LIMIT;
      alpha_r         <= RST_FILTER_ALPHA;
      speed_gain_r    <= RST_SPEED_GAIN;
      prop_gain_r     <= RST_PROP_GAIN;
      integ_gain_r    <= RST_INTEG_GAIN;
      integ_limit_r   <= RST_INTEG_LIMIT;
      yfilt_r         <= '0;
      integ_r         <= '0;
      impulse_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.idx)
          CFG_COUNT_OFFSET:  count_offset_r  <= cfg_ch.data;
          CFG_RPM_PER_COUNT: rpm_per_count_r <= cfg_ch.data[9:0];
          CFG_RPM_LIMIT:     rpm_limit_r     <= cfg_ch.data[14:0];
          CFG_FILTER_ALPHA:  alpha_r         <= cfg_ch.data;
          CFG_SPEED_GAIN:    speed_gain_r    <= cfg_ch.data;
          CFG_PROP_GAIN:     prop_gain_r     <= cfg_ch.data;
          CFG_INTEG_GAIN:    integ_gain_r    <= cfg_ch.data;
          CFG_INTEG_LIMIT:   integ_limit_r   <= cfg_ch.data[14:0];
          default: ;
        endcase
      end
      // impulse total accumulates offset - count for each accepted sample
      if (in_acc)                          impulse_r <= impulse_r - 32'(diff);
      if (state_r == ST_FILT && mrsp.done) yfilt_r   <= ynew;
      if (state_r == ST_MEAS && mrsp.done) integ_r   <= iclamp[15:0];
      if (state_r == ST_OUT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) target_r <= in_ch.target_speed;
    if (state_r == ST_RAW && mrsp.done) rej_r <= rej;
    if (state_r == ST_MEAS && mrsp.done) begin
      meas_r <= meas;
      err_r  <= err;
    end
    if (state_r == ST_PROP && mrsp.done) pterm_r <= $signed(mrsp.acc[33:8]);
    if (state_r == ST_INTG && mrsp.done) begin
      if (dsum > 27'sd32767)       drive_r <= 16'sh7fff;
      else if (dsum < -27'sd32768) drive_r <= -16'sh8000;
      else                         drive_r <= dsum[15:0];
    end
    if (state_r == ST_OUT && out_load) begin
      o_drive_r <= drive_r;
      o_meas_r  <= meas_r;
      o_err_r   <= err_r;
      o_rpm_r   <= yfilt_r[31:16];
      o_rej_r   <= rej_r;
      o_imp_r   <= impulse_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive_speed    = o_drive_r;
  assign out_ch.measured_speed = o_meas_r;
  assign out_ch.speed_error    = o_err_r;
  assign out_ch.filtered_rpm   = o_rpm_r;
  assign out_ch.rpm_rejected   = o_rej_r;
  assign out_ch.impulse_total  = o_imp_r;

endmodule

`default_nettype wire

[rtl/spc_chk.sv]
// ----------------------------------------------------------------------------
// spc_chk: port-level checks for the encoder speed PI controller
// Handshake behavior of the sample and result channels, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_drive,
  input wire        cfg_ready
);

  // a result held back keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("result changed while stalled");

  // one sample at a time: taking one closes the input
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after accept");

  // a new result appears as the sequencer returns to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result without return to idle");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind encoder_speed_pi_controller_unit spc_chk u_spc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_drive (out_ch.drive_speed),
  .cfg_ready (cfg_ch.ready)
);

`default_nettype wire
